// ===== rtl/eatr_pkg.sv =====
// Shared types, widths and constants for the Euler-angle rotation block.
`default_nettype none
package eatr_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int ENTRY_BITS = 16;
   localparam int QF         = 30;
   localparam int ANG_SHIFT  = QF - (ANGLE_BITS - 4);
   localparam int AW         = 36;  // signed Q30 angle before wrapping
   localparam int MW         = 32;  // magnitude after wrapping, below pi
   localparam int QW         = 32;  // signed Q30 sine, cosine and matrix terms

   localparam int LANE_STAGES  = 18;
   localparam int MERGE_STAGES = 4;
   localparam int NUM_STAGES   = 1 + LANE_STAGES + MERGE_STAGES;

   localparam logic signed [AW-1:0] Q_PI_S     = 36'sd3373259426;
   localparam logic signed [AW-1:0] Q_TWO_PI_S = 36'sd6746518852;
   localparam logic [MW-1:0] P_PI         = 32'd3373259426;
   localparam logic [MW-1:0] P_HALF_PI    = 32'd1686629713;
   localparam logic [MW-1:0] P_QUARTER_PI = 32'd843314857;
   localparam logic [QF:0]   Q_ONE        = 31'd1073741824;

   // Horner divisors as reciprocal multipliers: q = (x * M) >> K, exact for x < 2^31
   localparam logic [31:0] SIN_M [5] = '{32'd2498890064, 32'd3817748708, 32'd3272356036,
                                         32'd3435973837, 32'd2863311531};
   localparam int          SIN_K [5] = '{38, 38, 37, 36, 34};
   localparam logic [31:0] COS_M [6] = '{32'd4164816772, 32'd3054198967, 32'd2454267027,
                                         32'd2290649225, 32'd2863311531, 32'd2147483648};
   localparam int          COS_K [6] = '{39, 38, 37, 36, 35, 32};

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] pitch_angle;
      logic signed [ANGLE_BITS-1:0] yaw_angle;
      logic signed [ANGLE_BITS-1:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [ENTRY_BITS-1:0] m00;
      logic signed [ENTRY_BITS-1:0] m01;
      logic signed [ENTRY_BITS-1:0] m02;
      logic signed [ENTRY_BITS-1:0] m10;
      logic signed [ENTRY_BITS-1:0] m11;
      logic signed [ENTRY_BITS-1:0] m12;
      logic signed [ENTRY_BITS-1:0] m20;
      logic signed [ENTRY_BITS-1:0] m21;
      logic signed [ENTRY_BITS-1:0] m22;
   } rsp_type;

   typedef struct packed {
      logic signed [QW-1:0] s;
      logic signed [QW-1:0] c;
   } sc_type;

endpackage
`default_nettype wire

// ===== rtl/eatr_lane.sv =====
// One sine/cosine lane: range reduction, folding and pipelined Horner series.
`default_nettype none
module eatr_lane (
   input  logic                                   clock,
   input  logic [eatr_pkg::LANE_STAGES-1:0]       en,
   input  logic signed [eatr_pkg::ANGLE_BITS:0]   angle,
   output eatr_pkg::sc_type                       sc
);
   import eatr_pkg::*;

   typedef struct packed {
      logic sneg;
      logic cneg;
      logic swap;
   } fold_type;

   logic signed [AW-1:0] a_in;
   logic signed [AW-1:0] wrap_in, wrap_ff;
   logic [MW-1:0]        mag_in, mag_ff;
   logic                 sneg_ff, sneg2_ff;
   logic [MW-1:0]        half_in, half_ff;
   logic                 cneg_ff;
   logic [QF-1:0]        t_in, t_ff;
   fold_type             f_ff;
   logic [2*QF-1:0]      tsq;
   logic [QF-1:0]        t2_ff, t5_ff;
   fold_type             f5_ff;

   // wrap into [-pi, pi]
   always_comb begin
      a_in = AW'(angle) <<< ANG_SHIFT;
      if (a_in > Q_PI_S) begin
         wrap_in = a_in - Q_TWO_PI_S;
      end else if (a_in < -Q_PI_S) begin
         wrap_in = a_in + Q_TWO_PI_S;
      end else begin
         wrap_in = a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         wrap_ff <= wrap_in;
      end
   end

   assign mag_in = wrap_ff[AW-1] ? MW'(-wrap_ff) : MW'(wrap_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         mag_ff  <= mag_in;
         sneg_ff <= wrap_ff[AW-1];
      end
   end

   assign half_in = (mag_ff > P_HALF_PI) ? (P_PI - mag_ff) : mag_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         half_ff  <= half_in;
         cneg_ff  <= (mag_ff > P_HALF_PI);
         sneg2_ff <= sneg_ff;
      end
   end

   assign t_in = (half_ff > P_QUARTER_PI) ? QF'(P_HALF_PI - half_ff) : QF'(half_ff);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         t_ff <= t_in;
         f_ff <= '{sneg: sneg2_ff, cneg: cneg_ff, swap: (half_ff > P_QUARTER_PI)};
      end
   end

   assign tsq = t_ff * t_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         t2_ff <= tsq[2*QF-1:QF];
         t5_ff <= t_ff;
         f5_ff <= f_ff;
      end
   end

   // Horner steps: a multiply stage then a divide-by-constant stage; the last sine step does not divide
   logic [QF-1:0] t_st  [0:6];
   logic [QF-1:0] t2_st [0:6];
   fold_type      f_st  [0:6];
   logic [QF:0]   hs_st [0:6];
   logic [QF:0]   hc_st [0:6];

   assign t_st[0]  = t5_ff;
   assign t2_st[0] = t2_ff;
   assign f_st[0]  = f5_ff;
   assign hs_st[0] = Q_ONE;
   assign hc_st[0] = Q_ONE;

   for (genvar i = 0; i < 6; i++) begin : g_step
      logic [2*QF:0]   ps_full, pc_full;
      logic [QF:0]     ps_ff, pc_ff;
      logic [QF-1:0]   tm_ff, t2m_ff, td_ff, t2d_ff;
      fold_type        fm_ff, fd_ff;
      logic [QF:0]     hs_in, hc_in, hs_ff, hc_ff;
      logic [2*QF+2:0] qc_full;

      if (i < 5) begin : g_sin_div
         logic [2*QF+2:0] qs_full;
         assign ps_full = (2*QF+1)'(t2_st[i]) * (2*QF+1)'(hs_st[i]);
         assign qs_full = (2*QF+3)'(ps_ff) * (2*QF+3)'(SIN_M[i]);
         assign hs_in   = Q_ONE - (QF+1)'(qs_full >> SIN_K[i]);
      end else begin : g_sin_last
         assign ps_full = (2*QF+1)'(t_st[i]) * (2*QF+1)'(hs_st[i]);
         assign hs_in   = ps_ff;
      end

      assign pc_full = (2*QF+1)'(t2_st[i]) * (2*QF+1)'(hc_st[i]);
      assign qc_full = (2*QF+3)'(pc_ff) * (2*QF+3)'(COS_M[i]);
      assign hc_in   = Q_ONE - (QF+1)'(qc_full >> COS_K[i]);

      always_ff @(posedge clock) begin
         if (en[5+2*i]) begin
            ps_ff  <= ps_full[2*QF:QF];
            pc_ff  <= pc_full[2*QF:QF];
            tm_ff  <= t_st[i];
            t2m_ff <= t2_st[i];
            fm_ff  <= f_st[i];
         end
         if (en[6+2*i]) begin
            hs_ff  <= hs_in;
            hc_ff  <= hc_in;
            td_ff  <= tm_ff;
            t2d_ff <= t2m_ff;
            fd_ff  <= fm_ff;
         end
      end

      assign t_st[i+1]  = td_ff;
      assign t2_st[i+1] = t2d_ff;
      assign f_st[i+1]  = fd_ff;
      assign hs_st[i+1] = hs_ff;
      assign hc_st[i+1] = hc_ff;
   end

   // undo the folds: swap, then apply signs
   logic [QF:0]          s_sel, c_sel;
   logic signed [QW-1:0] s_ext, c_ext;
   sc_type               sc_ff;

   always_comb begin
      s_sel = f_st[6].swap ? hc_st[6] : hs_st[6];
      c_sel = f_st[6].swap ? hs_st[6] : hc_st[6];
      s_ext = signed'(QW'(s_sel));
      c_ext = signed'(QW'(c_sel));
   end

   always_ff @(posedge clock) begin
      if (en[LANE_STAGES-1]) begin
         sc_ff.s <= f_st[6].sneg ? -s_ext : s_ext;
         sc_ff.c <= f_st[6].cneg ? -c_ext : c_ext;
      end
   end

   assign sc = sc_ff;

endmodule
`default_nettype wire

// ===== rtl/eatr_merge.sv =====
// Merge stage: combines the three lanes into the rotation matrix Rx*Ry*Rz.
`default_nettype none
module eatr_merge (
   input  logic                              clock,
   input  logic [eatr_pkg::MERGE_STAGES-1:0] en,
   input  eatr_pkg::sc_type                  x,
   input  eatr_pkg::sc_type                  y,
   input  eatr_pkg::sc_type                  z,
   output eatr_pkg::rsp_type                 rsp
);
   import eatr_pkg::*;

   localparam int SH = QF - (ENTRY_BITS - 2);
   localparam logic signed [QW+1:0] RND = (QW+2)'((64'sd1 <<< SH) >>> 1);
   localparam logic signed [QW+1:0] LIM = (QW+2)'(64'sd1 <<< (ENTRY_BITS - 2));

   function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
      logic signed [2*QW-1:0] p;
      p = a * b;
      return p[QF+QW-1:QF];
   endfunction

   function automatic logic signed [ENTRY_BITS-1:0] to_entry(input logic signed [QW:0] v);
      logic signed [QW+1:0] r;
      r = ((QW+2)'(v) + RND) >>> SH;
      if (r > LIM) begin
         r = LIM;
      end else if (r < -LIM) begin
         r = -LIM;
      end
      return r[ENTRY_BITS-1:0];
   endfunction

   // first product: Rx*Ry terms and the first row
   logic signed [QW-1:0] r10_ff, r12_ff, r20_ff, r22_ff, m00_ff, m01_ff, m02_ff;
   logic signed [QW-1:0] cx_ff, nsx_ff, sz_ff, nsz_ff, cz_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r10_ff <= qmul(x.s, y.s);
         r12_ff <= qmul(x.s, y.c);
         r20_ff <= qmul(x.c, y.s);
         r22_ff <= qmul(x.c, y.c);
         m00_ff <= qmul(y.c, z.c);
         m01_ff <= qmul(y.c, z.s);
         m02_ff <= -y.s;
         cx_ff  <= x.c;
         nsx_ff <= -x.s;
         sz_ff  <= z.s;
         nsz_ff <= -z.s;
         cz_ff  <= z.c;
      end
   end

   // second product: rows one and two times Rz
   logic signed [QW-1:0] p10a_ff, p10b_ff, p11a_ff, p11b_ff;
   logic signed [QW-1:0] p20a_ff, p20b_ff, p21a_ff, p21b_ff;
   logic signed [QW-1:0] q00_ff, q01_ff, q02_ff, q12_ff, q22_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p10a_ff <= qmul(r10_ff, cz_ff);
         p10b_ff <= qmul(cx_ff, nsz_ff);
         p11a_ff <= qmul(r10_ff, sz_ff);
         p11b_ff <= qmul(cx_ff, cz_ff);
         p20a_ff <= qmul(r20_ff, cz_ff);
         p20b_ff <= qmul(nsx_ff, nsz_ff);
         p21a_ff <= qmul(r20_ff, sz_ff);
         p21b_ff <= qmul(nsx_ff, cz_ff);
         q00_ff  <= m00_ff;
         q01_ff  <= m01_ff;
         q02_ff  <= m02_ff;
         q12_ff  <= r12_ff;
         q22_ff  <= r22_ff;
      end
   end

   logic signed [QW:0] sum_ff [9];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sum_ff[0] <= (QW+1)'(q00_ff);
         sum_ff[1] <= (QW+1)'(q01_ff);
         sum_ff[2] <= (QW+1)'(q02_ff);
         sum_ff[3] <= (QW+1)'(p10a_ff) + (QW+1)'(p10b_ff);
         sum_ff[4] <= (QW+1)'(p11a_ff) + (QW+1)'(p11b_ff);
         sum_ff[5] <= (QW+1)'(q12_ff);
         sum_ff[6] <= (QW+1)'(p20a_ff) + (QW+1)'(p20b_ff);
         sum_ff[7] <= (QW+1)'(p21a_ff) + (QW+1)'(p21b_ff);
         sum_ff[8] <= (QW+1)'(q22_ff);
      end
   end

   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         rsp_ff.m00 <= to_entry(sum_ff[0]);
         rsp_ff.m01 <= to_entry(sum_ff[1]);
         rsp_ff.m02 <= to_entry(sum_ff[2]);
         rsp_ff.m10 <= to_entry(sum_ff[3]);
         rsp_ff.m11 <= to_entry(sum_ff[4]);
         rsp_ff.m12 <= to_entry(sum_ff[5]);
         rsp_ff.m20 <= to_entry(sum_ff[6]);
         rsp_ff.m21 <= to_entry(sum_ff[7]);
         rsp_ff.m22 <= to_entry(sum_ff[8]);
      end
   end

   assign rsp = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/euler_angles_to_rotation_top.sv =====
// Top level of the Euler-angle to rotation-matrix block.
//
// Usage: a request carries three signed Q3.12 angles (pitch, yaw, roll, in
// radians); the response carries the nine signed Q1.14 entries of the 3x3
// matrix Rx*Ry*Rz. Both channels use valid/ready; a transfer happens on a
// clock edge where valid and ready are both high.
// csr_wr_en/csr_wr_data set the axis-order mode: 0 puts pitch on x, yaw on y
// and roll on z; 1 puts roll on x, negated pitch on y and yaw on z. Write it
// only while no request is in flight.
// Throughput: one request per cycle while rsp_ready is high. Pipeline from
// acceptance to rsp_valid: one capture stage, 18 stages in each of the three
// sine/cosine lanes, whose 12 Horner stages dominate, and 4 matrix merge stages.
// Stalls: every stage holds its own valid bit, so when rsp_ready is low the
// result waits in the output register while earlier stages keep filling any
// bubbles; req_ready drops only once every stage holds a request.
// Reset: synchronous, active high; clears all valid bits and the mode to 0.
`default_nettype none
module euler_angles_to_rotation_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  eatr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output eatr_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import eatr_pkg::*;

   logic                    mode_ff;
   logic [NUM_STAGES-1:0]   v_ff, v_in, en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // a stage may load unless it and every stage after it is full and the
   // output is held
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
      assign en[i] = rsp_ready || !(&v_ff[NUM_STAGES-1:i]);
   end

   assign v_in = (en & {v_ff[NUM_STAGES-2:0], req_valid}) | (~en & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NUM_STAGES-1];

   // capture stage: map angles to axes by mode
   logic signed [ANGLE_BITS:0] ax_ff, ay_ff, az_ff;
   logic signed [ANGLE_BITS:0] pitch_x, yaw_x, roll_x;

   assign pitch_x = (ANGLE_BITS+1)'(req_data.pitch_angle);
   assign yaw_x   = (ANGLE_BITS+1)'(req_data.yaw_angle);
   assign roll_x  = (ANGLE_BITS+1)'(req_data.roll_angle);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ax_ff <= mode_ff ? roll_x : pitch_x;
         ay_ff <= mode_ff ? -pitch_x : yaw_x;
         az_ff <= mode_ff ? yaw_x : roll_x;
      end
   end

   sc_type sc_x, sc_y, sc_z;

   eatr_lane u_lane_x (
      .clock (clock),
      .en    (en[LANE_STAGES:1]),
      .angle (ax_ff),
      .sc    (sc_x)
   );

   eatr_lane u_lane_y (
      .clock (clock),
      .en    (en[LANE_STAGES:1]),
      .angle (ay_ff),
      .sc    (sc_y)
   );

   eatr_lane u_lane_z (
      .clock (clock),
      .en    (en[LANE_STAGES:1]),
      .angle (az_ff),
      .sc    (sc_z)
   );

   eatr_merge u_merge (
      .clock (clock),
      .en    (en[NUM_STAGES-1:LANE_STAGES+1]),
      .x     (sc_x),
      .y     (sc_y),
      .z     (sc_z),
      .rsp   (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/eatr_checker.sv =====
// Port-level checks for the rotation block, bound to its top level.
`default_nettype none
module eatr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input eatr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input eatr_pkg::rsp_type rsp_data,
   input logic              csr_wr_en,
   input logic              csr_wr_data
);
   import eatr_pkg::*;

   localparam int ELIM = 1 << (ENTRY_BITS - 2);

   logic in_range;

   always_comb begin
      in_range = 1'b1;
      if (rsp_data.m00 > ELIM || rsp_data.m00 < -ELIM) in_range = 1'b0;
      if (rsp_data.m01 > ELIM || rsp_data.m01 < -ELIM) in_range = 1'b0;
      if (rsp_data.m02 > ELIM || rsp_data.m02 < -ELIM) in_range = 1'b0;
      if (rsp_data.m10 > ELIM || rsp_data.m10 < -ELIM) in_range = 1'b0;
      if (rsp_data.m11 > ELIM || rsp_data.m11 < -ELIM) in_range = 1'b0;
      if (rsp_data.m12 > ELIM || rsp_data.m12 < -ELIM) in_range = 1'b0;
      if (rsp_data.m20 > ELIM || rsp_data.m20 < -ELIM) in_range = 1'b0;
      if (rsp_data.m21 > ELIM || rsp_data.m21 < -ELIM) in_range = 1'b0;
      if (rsp_data.m22 > ELIM || rsp_data.m22 < -ELIM) in_range = 1'b0;
   end

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // held response keeps valid and data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // every entry is clamped to [-1, +1]
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_range)
      else $error("matrix entry out of range");

   // with an empty output stage a request is always taken
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output stage");

endmodule

bind euler_angles_to_rotation_top eatr_checker u_eatr_checker (.*);
`default_nettype wire
